// File: rtl/dfa_token_scanner_defines.svh
// ---------------------------------------------------------------------------
// dfa_token_scanner_defines: assertion macros
// Shared property forms for the token scanner checks.
// ---------------------------------------------------------------------------
`ifndef DFA_TOKEN_SCANNER_DEFINES_SVH
`define DFA_TOKEN_SCANNER_DEFINES_SVH

// same-cycle implication, disabled in reset
`define DTS_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled in reset
`define DTS_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: rtl/dts_pkg.sv
// ---------------------------------------------------------------------------
// dts_pkg: token scanner package
// Widths, automaton state codes, result codes and shared record types.
// ---------------------------------------------------------------------------
package dts_pkg;

	// sizes
	localparam int KW_MAX_LEN = 6;
	localparam int POS_BITS   = 16;
	localparam int LEN_BITS   = $clog2(KW_MAX_LEN + 2);

	// automaton state codes
	typedef logic [3:0] scan_state_t;
	localparam scan_state_t ST_START    = 4'd0;
	localparam scan_state_t ST_WORD     = 4'd1;
	localparam scan_state_t ST_ZERO     = 4'd2;
	localparam scan_state_t ST_HEX      = 4'd3;
	localparam scan_state_t ST_DEC      = 4'd4;
	localparam scan_state_t ST_LT       = 4'd5;
	localparam scan_state_t ST_GT       = 4'd6;
	localparam scan_state_t ST_EQ       = 4'd7;
	localparam scan_state_t ST_AMP      = 4'd8;
	localparam scan_state_t ST_BAR      = 4'd9;
	localparam scan_state_t ST_OCT      = 4'd10;
	localparam scan_state_t ST_SLASH    = 4'd11;
	localparam scan_state_t ST_CMT      = 4'd12;
	localparam scan_state_t ST_CMT_STAR = 4'd13;

	// result status codes
	localparam logic [1:0] STAT_TOKEN = 2'd0;
	localparam logic [1:0] STAT_BAD   = 2'd1;
	localparam logic [1:0] STAT_FATAL = 2'd2;

	// input kind codes
	localparam logic KIND_CHAR = 1'b0;
	localparam logic KIND_END  = 1'b1;

	typedef logic [KW_MAX_LEN-1:0][7:0] word_buf_t;

	// scanner control state
	typedef struct packed {
		scan_state_t         state;
		logic [POS_BITS-1:0] row;
		logic [POS_BITS-1:0] col;
		logic [LEN_BITS-1:0] wlen;
		logic                halted;
	} scan_ctx_t;

	// one result item
	typedef struct packed {
		logic [1:0]          status;
		logic [4:0]          code;
		logic [POS_BITS-1:0] line;
		logic [POS_BITS-1:0] col;
		logic [7:0]          bad;
		logic                last;
	} result_t;

	// everything one step produces
	typedef struct packed {
		scan_ctx_t           ctx;
		logic                wr_en;
		logic [LEN_BITS-1:0] wr_idx;
		logic [7:0]          wr_data;
		logic [1:0]          count;
		result_t             res0;
		result_t             res1;
	} step_out_t;

endpackage

// File: rtl/dts_step.sv
// ---------------------------------------------------------------------------
// dts_step: one scanner transition
// Combinational next state, word buffer write and up to two results for one
// character or end-of-input item.
// ---------------------------------------------------------------------------
module dts_step (
	input  dts_pkg::scan_ctx_t ctx,
	input  dts_pkg::word_buf_t wbuf,
	input  logic               kind,
	input  logic [7:0]         char_code,
	output dts_pkg::step_out_t step
);

	// character constants
	localparam logic [7:0] CH_LF     = 8'h0A;
	localparam logic [7:0] CH_CR     = 8'h0D;
	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_LBRACK = 8'h5B;
	localparam logic [7:0] CH_RBRACK = 8'h5D;
	localparam logic [7:0] CH_LPAREN = 8'h28;
	localparam logic [7:0] CH_RPAREN = 8'h29;
	localparam logic [7:0] CH_SEMI   = 8'h3B;
	localparam logic [7:0] CH_BANG   = 8'h21;
	localparam logic [7:0] CH_COMMA  = 8'h2C;
	localparam logic [7:0] CH_PLUS   = 8'h2B;
	localparam logic [7:0] CH_MINUS  = 8'h2D;
	localparam logic [7:0] CH_LBRACE = 8'h7B;
	localparam logic [7:0] CH_RBRACE = 8'h7D;
	localparam logic [7:0] CH_ZERO   = 8'h30;
	localparam logic [7:0] CH_ONE    = 8'h31;
	localparam logic [7:0] CH_SEVEN  = 8'h37;
	localparam logic [7:0] CH_NINE   = 8'h39;
	localparam logic [7:0] CH_LT     = 8'h3C;
	localparam logic [7:0] CH_GT     = 8'h3E;
	localparam logic [7:0] CH_EQ     = 8'h3D;
	localparam logic [7:0] CH_AMP    = 8'h26;
	localparam logic [7:0] CH_BAR    = 8'h7C;
	localparam logic [7:0] CH_SLASH  = 8'h2F;
	localparam logic [7:0] CH_STAR   = 8'h2A;
	localparam logic [7:0] CH_LX     = 8'h78;
	localparam logic [7:0] CH_UX     = 8'h58;

	// token codes
	localparam logic [4:0] TK_IDENT  = 5'd1;
	localparam logic [4:0] TK_NUMBER = 5'd2;
	localparam logic [4:0] TK_PLUS   = 5'd3;
	localparam logic [4:0] TK_MINUS  = 5'd4;
	localparam logic [4:0] TK_ASSIGN = 5'd5;
	localparam logic [4:0] TK_EQ     = 5'd6;
	localparam logic [4:0] TK_GT     = 5'd7;
	localparam logic [4:0] TK_LT     = 5'd8;
	localparam logic [4:0] TK_NE     = 5'd9;
	localparam logic [4:0] TK_GE     = 5'd10;
	localparam logic [4:0] TK_LE     = 5'd11;
	localparam logic [4:0] TK_LPAREN = 5'd12;
	localparam logic [4:0] TK_RPAREN = 5'd13;
	localparam logic [4:0] TK_SEMI   = 5'd14;
	localparam logic [4:0] TK_AND    = 5'd15;
	localparam logic [4:0] TK_OR     = 5'd16;
	localparam logic [4:0] TK_NOT    = 5'd17;
	localparam logic [4:0] TK_LBRACK = 5'd18;
	localparam logic [4:0] TK_RBRACK = 5'd19;
	localparam logic [4:0] TK_IF     = 5'd20;
	localparam logic [4:0] TK_ELSE   = 5'd21;
	localparam logic [4:0] TK_INT    = 5'd22;
	localparam logic [4:0] TK_CHAR   = 5'd23;
	localparam logic [4:0] TK_BOOL   = 5'd24;
	localparam logic [4:0] TK_WHILE  = 5'd25;
	localparam logic [4:0] TK_GET    = 5'd26;
	localparam logic [4:0] TK_PUT    = 5'd27;
	localparam logic [4:0] TK_STRUCT = 5'd28;
	localparam logic [4:0] TK_COMMA  = 5'd29;
	localparam logic [4:0] TK_LBRACE = 5'd30;
	localparam logic [4:0] TK_RBRACE = 5'd31;
	localparam logic [4:0] TK_NONE   = 5'd0;

	localparam logic [dts_pkg::LEN_BITS-1:0] LEN_MAX  = dts_pkg::LEN_BITS'(dts_pkg::KW_MAX_LEN);
	localparam logic [dts_pkg::LEN_BITS-1:0] LEN_LONG =
		dts_pkg::LEN_BITS'(dts_pkg::KW_MAX_LEN + 1);

	// outcome of scanning a character from the start state
	typedef struct packed {
		logic                  emit;
		logic [1:0]            status;
		logic [4:0]            code;
		dts_pkg::scan_state_t  state;
		logic                  word_start;
	} start_t;

	function automatic logic is_letter(input logic [7:0] c);
		return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A);
	endfunction

	function automatic logic is_digit(input logic [7:0] c);
		return c >= CH_ZERO && c <= CH_NINE;
	endfunction

	function automatic logic is_oct(input logic [7:0] c);
		return c >= CH_ONE && c <= CH_SEVEN;
	endfunction

	function automatic logic is_hex(input logic [7:0] c);
		return is_digit(c) || (c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46);
	endfunction

	function automatic logic [dts_pkg::POS_BITS-1:0] sat_add(
		input logic [dts_pkg::POS_BITS-1:0] v,
		input logic [2:0]                   d
	);
		logic [dts_pkg::POS_BITS:0] s;
		s = {1'b0, v} + (dts_pkg::POS_BITS + 1)'(d);
		return s[dts_pkg::POS_BITS] ? '1 : s[dts_pkg::POS_BITS-1:0];
	endfunction

	// keyword lookup, only for words of at most the keyword length
	function automatic logic [4:0] kw_code(
		input dts_pkg::word_buf_t           b,
		input logic [dts_pkg::LEN_BITS-1:0] len
	);
		logic [4:0] r;
		r = TK_IDENT;
		unique case (len)
			dts_pkg::LEN_BITS'(2): begin
				if ({b[0], b[1]} == "if") r = TK_IF;
			end
			dts_pkg::LEN_BITS'(3): begin
				if ({b[0], b[1], b[2]} == "int") r = TK_INT;
				else if ({b[0], b[1], b[2]} == "get") r = TK_GET;
				else if ({b[0], b[1], b[2]} == "put") r = TK_PUT;
			end
			dts_pkg::LEN_BITS'(4): begin
				if ({b[0], b[1], b[2], b[3]} == "else") r = TK_ELSE;
				else if ({b[0], b[1], b[2], b[3]} == "char") r = TK_CHAR;
				else if ({b[0], b[1], b[2], b[3]} == "bool") r = TK_BOOL;
			end
			dts_pkg::LEN_BITS'(5): begin
				if ({b[0], b[1], b[2], b[3], b[4]} == "while") r = TK_WHILE;
			end
			dts_pkg::LEN_BITS'(6): begin
				if ({b[0], b[1], b[2], b[3], b[4], b[5]} == "struct") r = TK_STRUCT;
			end
			default: r = TK_IDENT;
		endcase
		return r;
	endfunction

	// start-state decode
	function automatic start_t start_byte(input logic [7:0] c);
		start_t s;
		s = '{emit: 1'b1, status: dts_pkg::STAT_TOKEN, code: TK_NONE,
			state: dts_pkg::ST_START, word_start: 1'b0};
		unique case (c)
			CH_LBRACK: s.code = TK_LBRACK;
			CH_RBRACK: s.code = TK_RBRACK;
			CH_LPAREN: s.code = TK_LPAREN;
			CH_RPAREN: s.code = TK_RPAREN;
			CH_SEMI:   s.code = TK_SEMI;
			CH_BANG:   s.code = TK_NOT;
			CH_COMMA:  s.code = TK_COMMA;
			CH_PLUS:   s.code = TK_PLUS;
			CH_MINUS:  s.code = TK_MINUS;
			CH_LBRACE: s.code = TK_LBRACE;
			CH_RBRACE: s.code = TK_RBRACE;
			CH_ZERO:   begin s.emit = 1'b0; s.state = dts_pkg::ST_ZERO;  end
			CH_LT:     begin s.emit = 1'b0; s.state = dts_pkg::ST_LT;    end
			CH_GT:     begin s.emit = 1'b0; s.state = dts_pkg::ST_GT;    end
			CH_EQ:     begin s.emit = 1'b0; s.state = dts_pkg::ST_EQ;    end
			CH_AMP:    begin s.emit = 1'b0; s.state = dts_pkg::ST_AMP;   end
			CH_BAR:    begin s.emit = 1'b0; s.state = dts_pkg::ST_BAR;   end
			CH_SLASH:  begin s.emit = 1'b0; s.state = dts_pkg::ST_SLASH; end
			CH_SPACE:  s.emit = 1'b0;
			default: begin
				priority if (is_letter(c)) begin
					s.emit = 1'b0;
					s.state = dts_pkg::ST_WORD;
					s.word_start = 1'b1;
				end else if (is_digit(c)) begin
					// zero is decoded above, so this is 1..9
					s.emit = 1'b0;
					s.state = dts_pkg::ST_DEC;
				end else begin
					s.status = dts_pkg::STAT_BAD;
				end
			end
		endcase
		return s;
	endfunction

	start_t                       sb;
	dts_pkg::scan_ctx_t           nxt;
	logic                         e0, e1, use_start;
	logic [1:0]                   st0, st1;
	logic [4:0]                   code0, code1;
	logic [7:0]                   bad0, bad1;
	logic                         wr_en;
	logic [dts_pkg::LEN_BITS-1:0] wr_idx;

	assign sb = start_byte(char_code);

	// transition
	always_comb begin
		nxt       = ctx;
		e0        = 1'b0;
		e1        = 1'b0;
		use_start = 1'b0;
		st0       = dts_pkg::STAT_TOKEN;
		st1       = dts_pkg::STAT_TOKEN;
		code0     = TK_NONE;
		code1     = TK_NONE;
		bad0      = 8'h00;
		bad1      = 8'h00;
		wr_en     = 1'b0;
		wr_idx    = ctx.wlen;

		if (ctx.halted) begin
			nxt = ctx;
		end else if (kind == dts_pkg::KIND_END) begin
			// flush a pending word, number or operator; a lone slash or open comment yields nothing
			nxt.col   = sat_add(ctx.col, 3'd1);
			nxt.state = dts_pkg::ST_START;
			unique case (ctx.state)
				dts_pkg::ST_WORD: begin
					e0 = 1'b1;
					code0 = (ctx.wlen > LEN_MAX) ? TK_IDENT : kw_code(wbuf, ctx.wlen);
				end
				dts_pkg::ST_ZERO, dts_pkg::ST_HEX, dts_pkg::ST_DEC, dts_pkg::ST_OCT: begin
					e0 = 1'b1; code0 = TK_NUMBER;
				end
				dts_pkg::ST_LT: begin e0 = 1'b1; code0 = TK_LT; end
				dts_pkg::ST_GT: begin e0 = 1'b1; code0 = TK_GT; end
				dts_pkg::ST_EQ: begin e0 = 1'b1; code0 = TK_ASSIGN; end
				dts_pkg::ST_AMP, dts_pkg::ST_BAR: begin
					e0 = 1'b1; st0 = dts_pkg::STAT_FATAL; nxt.halted = 1'b1;
				end
				default: e0 = 1'b0;
			endcase
		end else if (char_code == CH_LF || char_code == CH_CR) begin
			nxt.row = sat_add(ctx.row, 3'd1);
			nxt.col = '0;
		end else if (char_code == CH_TAB) begin
			nxt.col = sat_add(ctx.col, 3'd4);
		end else begin
			nxt.col = sat_add(ctx.col, 3'd1);
			unique case (ctx.state)
				dts_pkg::ST_WORD: begin
					if (is_letter(char_code) || is_digit(char_code)) begin
						if (ctx.wlen < LEN_MAX) begin
							wr_en = 1'b1;
							nxt.wlen = ctx.wlen + dts_pkg::LEN_BITS'(1);
						end else begin
							nxt.wlen = LEN_LONG;
						end
					end else begin
						e0 = 1'b1;
						code0 = (ctx.wlen > LEN_MAX) ? TK_IDENT : kw_code(wbuf, ctx.wlen);
						use_start = 1'b1;
					end
				end
				dts_pkg::ST_ZERO: begin
					priority if (char_code == CH_LX || char_code == CH_UX)
						nxt.state = dts_pkg::ST_HEX;
					else if (is_oct(char_code))
						nxt.state = dts_pkg::ST_OCT;
					else begin
						e0 = 1'b1; code0 = TK_NUMBER; use_start = 1'b1;
					end
				end
				dts_pkg::ST_HEX: begin
					if (!is_hex(char_code)) begin
						e0 = 1'b1; code0 = TK_NUMBER; use_start = 1'b1;
					end
				end
				dts_pkg::ST_DEC: begin
					if (!is_digit(char_code)) begin
						e0 = 1'b1; code0 = TK_NUMBER; use_start = 1'b1;
					end
				end
				dts_pkg::ST_OCT: begin
					if (!is_oct(char_code)) begin
						e0 = 1'b1; code0 = TK_NUMBER; use_start = 1'b1;
					end
				end
				dts_pkg::ST_LT: begin
					e0 = 1'b1;
					nxt.state = dts_pkg::ST_START;
					priority if (char_code == CH_GT) code0 = TK_NE;
					else if (char_code == CH_EQ) code0 = TK_LE;
					else begin code0 = TK_LT; use_start = 1'b1; end
				end
				dts_pkg::ST_GT: begin
					e0 = 1'b1;
					nxt.state = dts_pkg::ST_START;
					if (char_code == CH_EQ) code0 = TK_GE;
					else begin code0 = TK_GT; use_start = 1'b1; end
				end
				dts_pkg::ST_EQ: begin
					e0 = 1'b1;
					nxt.state = dts_pkg::ST_START;
					if (char_code == CH_EQ) code0 = TK_EQ;
					else begin code0 = TK_ASSIGN; use_start = 1'b1; end
				end
				dts_pkg::ST_AMP: begin
					e0 = 1'b1;
					nxt.state = dts_pkg::ST_START;
					if (char_code == CH_AMP) code0 = TK_AND;
					else begin st0 = dts_pkg::STAT_FATAL; nxt.halted = 1'b1; end
				end
				dts_pkg::ST_BAR: begin
					e0 = 1'b1;
					nxt.state = dts_pkg::ST_START;
					if (char_code == CH_BAR) code0 = TK_OR;
					else begin st0 = dts_pkg::STAT_FATAL; nxt.halted = 1'b1; end
				end
				dts_pkg::ST_SLASH: begin
					if (char_code == CH_STAR) nxt.state = dts_pkg::ST_CMT;
					else begin
						e0 = 1'b1; st0 = dts_pkg::STAT_BAD; bad0 = char_code;
						use_start = 1'b1;
					end
				end
				dts_pkg::ST_CMT: begin
					if (char_code == CH_STAR) nxt.state = dts_pkg::ST_CMT_STAR;
				end
				dts_pkg::ST_CMT_STAR: begin
					priority if (char_code == CH_SLASH) nxt.state = dts_pkg::ST_START;
					else if (char_code != CH_STAR) nxt.state = dts_pkg::ST_CMT;
				end
				default: use_start = 1'b1;
			endcase

			// rescan from the start state
			if (use_start) begin
				nxt.state = sb.state;
				if (sb.word_start) begin
					wr_en = 1'b1;
					wr_idx = '0;
					nxt.wlen = dts_pkg::LEN_BITS'(1);
				end
				if (sb.emit) begin
					if (e0) begin
						e1 = 1'b1; st1 = sb.status; code1 = sb.code;
						bad1 = (sb.status == dts_pkg::STAT_BAD) ? char_code : 8'h00;
					end else begin
						e0 = 1'b1; st0 = sb.status; code0 = sb.code;
						bad0 = (sb.status == dts_pkg::STAT_BAD) ? char_code : 8'h00;
					end
				end
			end
		end
	end

	// pack the step record
	always_comb begin
		step.ctx     = nxt;
		step.wr_en   = wr_en;
		step.wr_idx  = wr_idx;
		step.wr_data = char_code;
		step.count   = {e1, e0 & ~e1};
		step.res0    = '{status: st0, code: code0, line: nxt.row, col: nxt.col,
			bad: bad0, last: ~e1};
		step.res1    = '{status: st1, code: code1, line: nxt.row, col: nxt.col,
			bad: bad1, last: 1'b1};
	end

endmodule

// File: rtl/dfa_token_scanner.sv
// ---------------------------------------------------------------------------
// dfa_token_scanner: streaming lexical scanner
// Input channel s_axis carries one source byte per item (tuser = 0) or the
// end-of-input mark (tuser = 1). Output channel m_axis carries result items:
// tuser is the status (token, skipped symbol, fatal), tdata the token code,
// row, column and offending byte; tlast marks the final result of an item.
// An input item yields zero, one or two results. An accepted item passes the
// input register and the result buffer before its first result is on m_axis.
// Throughput is one item per cycle while items yield at most one result each
// and the receiver takes them; items with two results can stall the input, as
// the single-result output port drains the two-entry result buffer.
// Reset (arst_n low) returns the automaton to its start state, row 1,
// column 0, clears the fatal halt and empties both stages. A stalled
// receiver fills the result buffer, then the input register, then drops
// s_axis_tready; nothing is lost. After a fatal result every item is taken
// and produces nothing until reset.
// ---------------------------------------------------------------------------
`include "dfa_token_scanner_defines.svh"

module dfa_token_scanner (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // [7:0] char_code
	input  logic [0:0]  s_axis_tuser,   // [0] kind
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [47:0] m_axis_tdata,   // [4:0] token_code, [20:5] line_number,
	                                    // [36:21] column_number, [44:37] bad_char
	output logic [1:0]  m_axis_tuser,   // [1:0] status
	output logic        m_axis_tlast
);

	localparam dts_pkg::scan_ctx_t CTX_RESET = '{
		state: dts_pkg::ST_START,
		row: dts_pkg::POS_BITS'(1),
		col: '0,
		wlen: '0,
		halted: 1'b0
	};

	// input register
	logic       valid_s1;
	logic       kind_s1;
	logic [7:0] char_s1;

	// scanner state
	dts_pkg::scan_ctx_t ctx_q;
	dts_pkg::word_buf_t wbuf_q;

	// result buffer
	dts_pkg::result_t res_q [2];
	logic [1:0]       res_cnt_q;
	dts_pkg::result_t res_d [2];
	logic [1:0]       res_cnt_d;

	dts_pkg::step_out_t step;
	logic               pop, fire;
	logic [1:0]         remain;

	dts_step u_step (
		.ctx       (ctx_q),
		.wbuf      (wbuf_q),
		.kind      (kind_s1),
		.char_code (char_s1),
		.step      (step)
	);

	// handshake
	assign pop    = m_axis_tvalid & m_axis_tready;
	assign remain = res_cnt_q - {1'b0, pop};
	assign fire   = valid_s1 & (({1'b0, remain} + {1'b0, step.count}) <= 3'd2);
	assign s_axis_tready = ~valid_s1 | fire;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			kind_s1 <= s_axis_tuser[0];
			char_s1 <= s_axis_tdata;
		end
	end

	// scanner state update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctx_q <= CTX_RESET;
		end else if (fire) begin
			ctx_q <= step.ctx;
		end
	end

	// word buffer, undefined until written
	always_ff @(posedge clk) begin
		if (fire && step.wr_en) begin
			wbuf_q[step.wr_idx] <= step.wr_data;
		end
	end

	// result buffer next value: shift out on pop, append new results
	always_comb begin
		res_d[0] = pop ? res_q[1] : res_q[0];
		res_d[1] = res_q[1];
		if (fire) begin
			unique case (remain)
				2'd0: begin
					res_d[0] = step.res0;
					res_d[1] = step.res1;
				end
				2'd1: res_d[1] = step.res0;
				default: res_d[1] = res_q[1];
			endcase
		end
		res_cnt_d = remain + (fire ? step.count : 2'd0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_cnt_q <= 2'd0;
		end else begin
			res_cnt_q <= res_cnt_d;
		end
	end

	always_ff @(posedge clk) begin
		res_q[0] <= res_d[0];
		res_q[1] <= res_d[1];
	end

	// output port
	assign m_axis_tvalid = (res_cnt_q != 2'd0);
	assign m_axis_tdata  = {3'b000, res_q[0].bad, res_q[0].col, res_q[0].line, res_q[0].code};
	assign m_axis_tuser  = res_q[0].status;
	assign m_axis_tlast  = res_q[0].last;

	// checks
	`DTS_ASSERT_NOW(a_res_cnt_range, 1'b1, res_cnt_q != 2'd3, "result buffer overfilled")
	`DTS_ASSERT_NEXT(a_halt_sticky, ctx_q.halted, ctx_q.halted, "halt cleared without reset")
	`DTS_ASSERT_NOW(a_halt_silent, fire && ctx_q.halted, step.count == 2'd0,
		"result produced while halted")
	`DTS_ASSERT_NOW(a_pair_last, fire && step.count == 2'd2, !step.res0.last && step.res1.last,
		"wrong last marking on a result pair")

endmodule
